### hw/rtl/i2cm_pkg.sv
// Shared types and constants for the I2C master byte engine.
package i2cm_pkg;

    // Widths of the timing registers and the configuration bus
    localparam int CFG_W    = 16;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;
    localparam int REG_IW   = 3;

    // Register indexes
    localparam logic [REG_IW-1:0] REG_SCL_LOW    = 3'd0;
    localparam logic [REG_IW-1:0] REG_SCL_HIGH   = 3'd1;
    localparam logic [REG_IW-1:0] REG_DATA_SETUP = 3'd2;
    localparam logic [REG_IW-1:0] REG_DATA_HOLD  = 3'd3;
    localparam logic [REG_IW-1:0] REG_START_HOLD = 3'd4;
    localparam logic [REG_IW-1:0] REG_STOP_SETUP = 3'd5;
    localparam logic [REG_IW-1:0] REG_BUS_FREE   = 3'd6;
    localparam logic [REG_IW-1:0] REG_ACK_TMO    = 3'd7;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_SCL_LOW    = 16'd100;
    localparam logic [CFG_W-1:0] RST_SCL_HIGH   = 16'd100;
    localparam logic [CFG_W-1:0] RST_DATA_SETUP = 16'd10;
    localparam logic [CFG_W-1:0] RST_DATA_HOLD  = 16'd5;
    localparam logic [CFG_W-1:0] RST_START_HOLD = 16'd60;
    localparam logic [CFG_W-1:0] RST_STOP_SETUP = 16'd60;
    localparam logic [CFG_W-1:0] RST_BUS_FREE   = 16'd130;
    localparam logic [CFG_W-1:0] RST_ACK_TMO    = 16'd250;

    // Command codes
    localparam logic [2:0] FUNC_NONE  = 3'd0;
    localparam logic [2:0] FUNC_START = 3'd1;
    localparam logic [2:0] FUNC_STOP  = 3'd2;
    localparam logic [2:0] FUNC_WRITE = 3'd3;
    localparam logic [2:0] FUNC_READ  = 3'd4;

    // Bits per data byte
    localparam logic [3:0] BYTE_BITS = 4'd8;

    typedef struct packed {
        logic [CFG_W-1:0] scl_low;
        logic [CFG_W-1:0] scl_high;
        logic [CFG_W-1:0] data_setup;
        logic [CFG_W-1:0] data_hold;
        logic [CFG_W-1:0] start_hold;
        logic [CFG_W-1:0] stop_setup;
        logic [CFG_W-1:0] bus_free;
        logic [CFG_W-1:0] ack_tmo;
    } cfg_t;

    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       ack_error;
    } res_t;

endpackage

### hw/rtl/i2c_master_byte_engine_core.sv
// Top level of the I2C master byte engine: input register, sequencer, result register.
//
// Each input item is one bus timing tick: a command code (none, start, stop,
// write byte, read byte), the byte to send, the ACK choice for a read and the
// sampled SDA level. Each accepted item yields exactly one result item: the
// open-drain pull-low controls for SCL and SDA, busy, a done pulse, the last
// received byte and the ACK error flag, all as seen after that tick.
// Both channels use valid/ready. An item is captured in the input register,
// then, once the result register is free, the sequencer updates its state and
// the result register together, so a result is offered from the result
// register, and one item is taken every cycle while the receiver takes each result.
// Phase changes are set by the phase-length compare on the tick counter.
// If the receiver stalls, the result waits in the result register; if the input
// register is empty, one more item is taken into it, and in_ready then stays low
// until the result is taken.
// The user must write the timing registers through the APB port only while the
// channels are idle; the block does not enforce this. Reset clears the sequencer
// and restores the default timing, not the result register; there is no clearing pass.
module i2c_master_byte_engine_core
    import i2cm_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        func,
    input  logic [7:0]        tx_byte,
    input  logic              send_ack,
    input  logic              sda_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              scl_pull_low,
    output logic              sda_pull_low,
    output logic              busy_res,
    output logic              done_res,
    output logic [7:0]        rx_byte,
    output logic              ack_error
);

    cfg_t       cfg;
    res_t       res;
    res_t       res_reg;
    logic       in_valid_reg;
    logic       out_valid_reg;
    logic [2:0] func_reg;
    logic [7:0] tx_byte_reg;
    logic       send_ack_reg;
    logic       sda_in_reg;
    logic       step_en;
    logic       res_free;

    i2cm_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    i2cm_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (step_en),
        .cfg      (cfg),
        .func     (func_reg),
        .tx_byte  (tx_byte_reg),
        .send_ack (send_ack_reg),
        .sda_in   (sda_in_reg),
        .res      (res)
    );

    // Advance when the result register is empty or being drained
    assign res_free = !out_valid_reg || out_ready;
    assign step_en  = in_valid_reg && res_free;
    assign in_ready = !in_valid_reg || res_free;

    // Hold the input item until the sequencer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            func_reg     <= func;
            tx_byte_reg  <= tx_byte;
            send_ack_reg <= send_ack;
            sda_in_reg   <= sda_in;
        end
    end

    // Hold the result item until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            res_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign scl_pull_low = res_reg.scl_pull_low;
    assign sda_pull_low = res_reg.sda_pull_low;
    assign busy_res     = res_reg.busy;
    assign done_res     = res_reg.done;
    assign rx_byte      = res_reg.rx_byte;
    assign ack_error    = res_reg.ack_error;

endmodule

### hw/rtl/i2cm_apb_regs.sv
// APB register bank holding the bus timing configuration.
module i2cm_apb_regs
    import i2cm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t             cfg_reg;
    logic [REG_IW-1:0] reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    // Write the addressed register in the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scl_low    <= RST_SCL_LOW;
            cfg_reg.scl_high   <= RST_SCL_HIGH;
            cfg_reg.data_setup <= RST_DATA_SETUP;
            cfg_reg.data_hold  <= RST_DATA_HOLD;
            cfg_reg.start_hold <= RST_START_HOLD;
            cfg_reg.stop_setup <= RST_STOP_SETUP;
            cfg_reg.bus_free   <= RST_BUS_FREE;
            cfg_reg.ack_tmo    <= RST_ACK_TMO;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_SCL_LOW:    cfg_reg.scl_low    <= pwdata[CFG_W-1:0];
                REG_SCL_HIGH:   cfg_reg.scl_high   <= pwdata[CFG_W-1:0];
                REG_DATA_SETUP: cfg_reg.data_setup <= pwdata[CFG_W-1:0];
                REG_DATA_HOLD:  cfg_reg.data_hold  <= pwdata[CFG_W-1:0];
                REG_START_HOLD: cfg_reg.start_hold <= pwdata[CFG_W-1:0];
                REG_STOP_SETUP: cfg_reg.stop_setup <= pwdata[CFG_W-1:0];
                REG_BUS_FREE:   cfg_reg.bus_free   <= pwdata[CFG_W-1:0];
                REG_ACK_TMO:    cfg_reg.ack_tmo    <= pwdata[CFG_W-1:0];
                default:        ;
            endcase
        end
    end

    // Return the addressed register
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_SCL_LOW:    prdata = APB_DW'(cfg_reg.scl_low);
            REG_SCL_HIGH:   prdata = APB_DW'(cfg_reg.scl_high);
            REG_DATA_SETUP: prdata = APB_DW'(cfg_reg.data_setup);
            REG_DATA_HOLD:  prdata = APB_DW'(cfg_reg.data_hold);
            REG_START_HOLD: prdata = APB_DW'(cfg_reg.start_hold);
            REG_STOP_SETUP: prdata = APB_DW'(cfg_reg.stop_setup);
            REG_BUS_FREE:   prdata = APB_DW'(cfg_reg.bus_free);
            REG_ACK_TMO:    prdata = APB_DW'(cfg_reg.ack_tmo);
            default:        prdata = '0;
        endcase
    end

endmodule

### hw/rtl/i2cm_step.sv
// Bus sequencer: phase state, tick counter and shifter, one tick per step.
module i2cm_step
    import i2cm_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  cfg_t       cfg,
    input  logic [2:0] func,
    input  logic [7:0] tx_byte,
    input  logic       send_ack,
    input  logic       sda_in,
    output res_t       res
);

    localparam int CMP_W = ((COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W) + 1;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_REL,
        PH_START_HIGH,
        PH_START_HOLD,
        PH_STOP_SCL,
        PH_STOP_SDA,
        PH_STOP_SETUP,
        PH_BUS_FREE,
        PH_BIT_HOLD,
        PH_BIT_SETUP,
        PH_BIT_LOW,
        PH_BIT_HIGH,
        PH_ACK_WAIT
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] tick_reg, tick_next;
    logic [3:0]             bit_reg, bit_next;
    logic [7:0]             shift_reg, shift_next;
    logic                   ack_choice_reg, ack_choice_next;
    logic                   scl_low_reg, scl_low_next;
    logic                   sda_low_reg, sda_low_next;
    logic [7:0]             rx_reg, rx_next;
    logic                   error_reg, error_next;
    logic                   read_mode_reg, read_mode_next;
    logic                   done;

    logic [CFG_W-1:0]       phase_len;
    logic [CMP_W-1:0]       tick_inc;
    logic                   tick_max;
    logic                   phase_end;
    logic                   tmo_hit;

    // Pick the duration of the current timed phase
    always_comb
    begin
        unique case (phase_reg)
            PH_START_REL:  phase_len = cfg.data_setup;
            PH_START_HIGH: phase_len = cfg.scl_high;
            PH_START_HOLD: phase_len = cfg.start_hold;
            PH_STOP_SCL:   phase_len = cfg.data_hold;
            PH_STOP_SDA:   phase_len = cfg.data_setup;
            PH_STOP_SETUP: phase_len = cfg.stop_setup;
            PH_BUS_FREE:   phase_len = cfg.bus_free;
            PH_BIT_HOLD:   phase_len = cfg.data_hold;
            PH_BIT_SETUP:  phase_len = cfg.data_setup;
            PH_BIT_LOW:    phase_len = cfg.scl_low;
            default:       phase_len = cfg.scl_high;
        endcase
    end

    // Phase ends after its length or when the counter saturates
    assign tick_inc  = CMP_W'(tick_reg) + CMP_W'(1);
    assign tick_max  = (tick_reg == {COUNT_WIDTH{1'b1}});
    assign phase_end = (tick_inc >= CMP_W'(phase_len)) || tick_max;
    assign tmo_hit   = (CMP_W'(tick_reg) >= CMP_W'(cfg.ack_tmo)) || tick_max;

    // Work out the state after one tick
    always_comb
    begin
        phase_next      = phase_reg;
        tick_next       = tick_reg;
        bit_next        = bit_reg;
        shift_next      = shift_reg;
        ack_choice_next = ack_choice_reg;
        scl_low_next    = scl_low_reg;
        sda_low_next    = sda_low_reg;
        rx_next         = rx_reg;
        error_next      = error_reg;
        read_mode_next  = read_mode_reg;
        done            = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            case (func) inside
                FUNC_START:
                begin
                    sda_low_next = 1'b0;
                    phase_next   = PH_START_REL;
                    tick_next    = '0;
                end
                FUNC_STOP:
                begin
                    scl_low_next = 1'b1;
                    phase_next   = PH_STOP_SCL;
                    tick_next    = '0;
                end
                FUNC_WRITE, FUNC_READ:
                begin
                    read_mode_next = (func == FUNC_READ);
                    if (func == FUNC_READ)
                    begin
                        shift_next      = '0;
                        ack_choice_next = send_ack;
                    end
                    else
                    begin
                        shift_next = tx_byte;
                        error_next = 1'b0;
                    end
                    bit_next     = '0;
                    scl_low_next = 1'b1;
                    phase_next   = PH_BIT_HOLD;
                    tick_next    = '0;
                end
                default: ;
            endcase
        end
        else if (phase_reg == PH_ACK_WAIT)
        begin
            // Poll the slave's acknowledge every tick
            if (!sda_in)
            begin
                scl_low_next = 1'b1;
                phase_next   = PH_IDLE;
                tick_next    = '0;
                done         = 1'b1;
            end
            else if (tmo_hit)
            begin
                error_next   = 1'b1;
                scl_low_next = 1'b1;
                phase_next   = PH_STOP_SCL;
                tick_next    = '0;
            end
            else
            begin
                tick_next = tick_reg + COUNT_WIDTH'(1);
            end
        end
        else if (!phase_end)
        begin
            tick_next = tick_reg + COUNT_WIDTH'(1);
        end
        else
        begin
            tick_next = '0;
            unique case (phase_reg)
                PH_START_REL:
                begin
                    scl_low_next = 1'b0;
                    phase_next   = PH_START_HIGH;
                end
                PH_START_HIGH:
                begin
                    sda_low_next = 1'b1;
                    phase_next   = PH_START_HOLD;
                end
                PH_START_HOLD:
                begin
                    scl_low_next = 1'b1;
                    phase_next   = PH_IDLE;
                    done         = 1'b1;
                end
                PH_STOP_SCL:
                begin
                    sda_low_next = 1'b1;
                    phase_next   = PH_STOP_SDA;
                end
                PH_STOP_SDA:
                begin
                    scl_low_next = 1'b0;
                    phase_next   = PH_STOP_SETUP;
                end
                PH_STOP_SETUP:
                begin
                    sda_low_next = 1'b0;
                    phase_next   = PH_BUS_FREE;
                end
                PH_BUS_FREE:
                begin
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                PH_BIT_HOLD:
                begin
                    // Drive the data bit, or the ACK bit once all data bits are out
                    if (bit_reg < BYTE_BITS)
                        sda_low_next = !read_mode_reg && !shift_reg[7];
                    else
                        sda_low_next = read_mode_reg && ack_choice_reg;
                    phase_next = PH_BIT_SETUP;
                end
                PH_BIT_SETUP:
                begin
                    phase_next = PH_BIT_LOW;
                end
                PH_BIT_LOW:
                begin
                    scl_low_next = 1'b0;
                    phase_next   = PH_BIT_HIGH;
                end
                default:
                begin
                    // End of the SCL high time: shift, finish the read or wait for ACK
                    if (bit_reg < BYTE_BITS)
                    begin
                        shift_next   = {shift_reg[6:0], read_mode_reg & sda_in};
                        bit_next     = bit_reg + 4'd1;
                        scl_low_next = 1'b1;
                        phase_next   = PH_BIT_HOLD;
                    end
                    else if (read_mode_reg)
                    begin
                        rx_next      = shift_reg;
                        scl_low_next = 1'b1;
                        phase_next   = PH_IDLE;
                        done         = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_ACK_WAIT;
                    end
                end
            endcase
        end
    end

    // Hold the sequencer state, advance it on each tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_reg       <= '0;
            bit_reg        <= '0;
            shift_reg      <= '0;
            ack_choice_reg <= 1'b0;
            scl_low_reg    <= 1'b0;
            sda_low_reg    <= 1'b0;
            rx_reg         <= '0;
            error_reg      <= 1'b0;
            read_mode_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            tick_reg       <= tick_next;
            bit_reg        <= bit_next;
            shift_reg      <= shift_next;
            ack_choice_reg <= ack_choice_next;
            scl_low_reg    <= scl_low_next;
            sda_low_reg    <= sda_low_next;
            rx_reg         <= rx_next;
            error_reg      <= error_next;
            read_mode_reg  <= read_mode_next;
        end
    end

    // Result of this tick, taken after the update
    assign res.scl_pull_low = scl_low_next;
    assign res.sda_pull_low = sda_low_next;
    assign res.busy         = (phase_next != PH_IDLE);
    assign res.done         = done;
    assign res.rx_byte      = rx_next;
    assign res.ack_error    = error_next;

endmodule

### tb/tb_i2c_master_byte_engine_core.sv
// Testbench for the I2C master byte engine: tick stimulus, line-state predictor and scoreboard.
import i2cm_pkg::*;

typedef enum logic [3:0] {
    PH_IDLE, PH_START_REL, PH_START_HIGH, PH_START_HOLD,
    PH_STOP_SCL, PH_STOP_SDA, PH_STOP_SETUP, PH_BUS_FREE,
    PH_BIT_HOLD, PH_BIT_SETUP, PH_BIT_LOW, PH_BIT_HIGH, PH_ACK_WAIT
} seq_phase_t;

class bus_tick_scoreboard;
    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_TOP = '1;

    cfg_t             cfg;
    seq_phase_t       phase;
    logic [CNT_W-1:0] tick_cnt;
    logic [3:0]       bit_idx;
    logic [7:0]       shifter;
    logic             ack_sel;
    logic             scl_low;
    logic             sda_low;
    logic [7:0]       rx_q;
    logic             err;
    logic             rd_mode;

    res_t expected_lines[$];
    int   ticks;
    int   dones;
    int   errors;

    function new();
        cfg.scl_low    = RST_SCL_LOW;
        cfg.scl_high   = RST_SCL_HIGH;
        cfg.data_setup = RST_DATA_SETUP;
        cfg.data_hold  = RST_DATA_HOLD;
        cfg.start_hold = RST_START_HOLD;
        cfg.stop_setup = RST_STOP_SETUP;
        cfg.bus_free   = RST_BUS_FREE;
        cfg.ack_tmo    = RST_ACK_TMO;
        phase    = PH_IDLE;
        tick_cnt = '0;
        bit_idx  = '0;
        shifter  = '0;
        ack_sel  = 1'b0;
        scl_low  = 1'b0;
        sda_low  = 1'b0;
        rx_q     = '0;
        err      = 1'b0;
        rd_mode  = 1'b0;
        ticks    = 0;
        dones    = 0;
        errors   = 0;
    endfunction

    function void set_reg(logic [REG_IW-1:0] idx, logic [CFG_W-1:0] val);
        case (idx)
            REG_SCL_LOW:    cfg.scl_low    = val;
            REG_SCL_HIGH:   cfg.scl_high   = val;
            REG_DATA_SETUP: cfg.data_setup = val;
            REG_DATA_HOLD:  cfg.data_hold  = val;
            REG_START_HOLD: cfg.start_hold = val;
            REG_STOP_SETUP: cfg.stop_setup = val;
            REG_BUS_FREE:   cfg.bus_free   = val;
            default:        cfg.ack_tmo    = val;
        endcase
    endfunction

    function bit busy();
        return phase != PH_IDLE;
    endfunction

    function bit waiting_ack();
        return phase == PH_ACK_WAIT;
    endfunction

    function int pending();
        return expected_lines.size();
    endfunction

    function void enter(seq_phase_t p);
        phase    = p;
        tick_cnt = '0;
    endfunction

    // Length of the current timed phase in ticks
    function logic [CFG_W-1:0] phase_span();
        case (phase) inside
            PH_START_REL, PH_STOP_SDA, PH_BIT_SETUP: return cfg.data_setup;
            PH_START_HIGH:                           return cfg.scl_high;
            PH_START_HOLD:                           return cfg.start_hold;
            PH_STOP_SCL, PH_BIT_HOLD:                return cfg.data_hold;
            PH_STOP_SETUP:                           return cfg.stop_setup;
            PH_BUS_FREE:                             return cfg.bus_free;
            PH_BIT_LOW:                              return cfg.scl_low;
            default:                                 return cfg.scl_high;
        endcase
    endfunction

    // Move on from a timed phase; returns 1 when the command completes
    function bit leave_phase(logic sda);
        case (phase)
            PH_START_REL:  begin scl_low = 1'b0; enter(PH_START_HIGH); return 1'b0; end
            PH_START_HIGH: begin sda_low = 1'b1; enter(PH_START_HOLD); return 1'b0; end
            PH_START_HOLD: begin scl_low = 1'b1; enter(PH_IDLE); return 1'b1; end
            PH_STOP_SCL:   begin sda_low = 1'b1; enter(PH_STOP_SDA); return 1'b0; end
            PH_STOP_SDA:   begin scl_low = 1'b0; enter(PH_STOP_SETUP); return 1'b0; end
            PH_STOP_SETUP: begin sda_low = 1'b0; enter(PH_BUS_FREE); return 1'b0; end
            PH_BUS_FREE:   begin enter(PH_IDLE); return 1'b1; end
            PH_BIT_HOLD:
            begin
                if (bit_idx < BYTE_BITS)
                    sda_low = rd_mode ? 1'b0 : ~shifter[7];
                else
                    sda_low = rd_mode ? ack_sel : 1'b0;
                enter(PH_BIT_SETUP);
                return 1'b0;
            end
            PH_BIT_SETUP:  begin enter(PH_BIT_LOW); return 1'b0; end
            PH_BIT_LOW:    begin scl_low = 1'b0; enter(PH_BIT_HIGH); return 1'b0; end
            default:
            begin
                if (bit_idx < BYTE_BITS)
                begin
                    shifter = {shifter[6:0], rd_mode ? sda : 1'b0};
                    bit_idx = bit_idx + 4'd1;
                    scl_low = 1'b1;
                    enter(PH_BIT_HOLD);
                    return 1'b0;
                end
                if (rd_mode)
                begin
                    rx_q    = shifter;
                    scl_low = 1'b1;
                    enter(PH_IDLE);
                    return 1'b1;
                end
                enter(PH_ACK_WAIT);
                return 1'b0;
            end
        endcase
    endfunction

    // Advance the predicted engine by one accepted tick and queue its line state
    function void note_tick(logic [2:0] f, logic [7:0] tx, logic sack, logic sda);
        logic [CFG_W-1:0] span;
        logic             fin;
        res_t             want;
        fin   = 1'b0;
        ticks = ticks + 1;
        if (phase == PH_IDLE)
        begin
            case (f) inside
                FUNC_START:
                begin
                    sda_low = 1'b0;
                    enter(PH_START_REL);
                end
                FUNC_STOP:
                begin
                    scl_low = 1'b1;
                    enter(PH_STOP_SCL);
                end
                FUNC_WRITE, FUNC_READ:
                begin
                    rd_mode = (f == FUNC_READ);
                    shifter = rd_mode ? 8'h00 : tx;
                    if (rd_mode)
                        ack_sel = sack;
                    else
                        err = 1'b0;
                    bit_idx = '0;
                    scl_low = 1'b1;
                    enter(PH_BIT_HOLD);
                end
                default: ;
            endcase
        end
        else if (phase == PH_ACK_WAIT)
        begin
            if (!sda)
            begin
                scl_low = 1'b1;
                enter(PH_IDLE);
                fin = 1'b1;
            end
            else if (tick_cnt >= cfg.ack_tmo || tick_cnt == CNT_TOP)
            begin
                err     = 1'b1;
                scl_low = 1'b1;
                enter(PH_STOP_SCL);
            end
            else
                tick_cnt = tick_cnt + CNT_W'(1);
        end
        else
        begin
            span = phase_span();
            if (({1'b0, tick_cnt} + 17'd1) >= {1'b0, span} || tick_cnt == CNT_TOP)
                fin = leave_phase(sda);
            else
                tick_cnt = tick_cnt + CNT_W'(1);
        end
        if (fin)
            dones = dones + 1;
        want.scl_pull_low = scl_low;
        want.sda_pull_low = sda_low;
        want.busy         = (phase != PH_IDLE);
        want.done         = fin;
        want.rx_byte      = rx_q;
        want.ack_error    = err;
        expected_lines.push_back(want);
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors = errors + 1;
        end
    endfunction

    // Compare one result item with the oldest predicted line state
    function void check_lines(res_t got);
        res_t want;
        if (expected_lines.size() == 0)
        begin
            $display("%0t: result item with nothing pending, expected none, actual %p",
                     $time, got);
            errors = errors + 1;
            return;
        end
        want = expected_lines.pop_front();
        cmp_field("scl_pull_low", 8'(want.scl_pull_low), 8'(got.scl_pull_low));
        cmp_field("sda_pull_low", 8'(want.sda_pull_low), 8'(got.sda_pull_low));
        cmp_field("busy_res", 8'(want.busy), 8'(got.busy));
        cmp_field("done_res", 8'(want.done), 8'(got.done));
        cmp_field("rx_byte", want.rx_byte, got.rx_byte);
        cmp_field("ack_error", 8'(want.ack_error), 8'(got.ack_error));
    endfunction
endclass

module tb_i2c_master_byte_engine_core;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [2:0]        func = FUNC_NONE;
    logic [7:0]        tx_byte = '0;
    logic              send_ack = 1'b0;
    logic              sda_in = 1'b1;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              scl_pull_low;
    logic              sda_pull_low;
    logic              busy_res;
    logic              done_res;
    logic [7:0]        rx_byte;
    logic              ack_error;

    logic              quiet = 1'b0;
    logic              hold_req = 1'b0;
    int                hold_left = 0;

    bus_tick_scoreboard sb;

    i2c_master_byte_engine_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .tx_byte      (tx_byte),
        .send_ack     (send_ack),
        .sda_in       (sda_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .scl_pull_low (scl_pull_low),
        .sda_pull_low (sda_pull_low),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .rx_byte      (rx_byte),
        .ack_error    (ack_error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: check accepted items, stall at random, hold off on request
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_lines('{scl_pull_low, sda_pull_low, busy_res, done_res, rx_byte,
                             ack_error});
        if (hold_req)
            hold_left = 400;
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (quiet)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 10);
    end

    // Offer one tick item and wait for it to be taken
    task automatic drive_tick(logic [2:0] f, logic [7:0] tx, logic sack, logic sda);
        if (!quiet)
            while ($urandom_range(99) < 10)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid <= 1'b1;
        func     <= f;
        tx_byte  <= tx;
        send_ack <= sack;
        sda_in   <= sda;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_tick(f, tx, sack, sda);
    endtask

    // Drop valid and wait until every result has come back and the pipe is empty
    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (sb.pending() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(logic [REG_IW-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_DW-CFG_W){1'b0}}, val};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    function automatic cfg_t make_timing(int lo, int hi, int su, int hd, int sth, int sts,
                                         int bf, int tmo);
        cfg_t c;
        c.scl_low    = lo[CFG_W-1:0];
        c.scl_high   = hi[CFG_W-1:0];
        c.data_setup = su[CFG_W-1:0];
        c.data_hold  = hd[CFG_W-1:0];
        c.start_hold = sth[CFG_W-1:0];
        c.stop_setup = sts[CFG_W-1:0];
        c.bus_free   = bf[CFG_W-1:0];
        c.ack_tmo    = tmo[CFG_W-1:0];
        return c;
    endfunction

    // Write the whole timing set once the engine has gone quiet
    task automatic load_timing(cfg_t c);
        drain();
        apb_write(REG_SCL_LOW, c.scl_low);
        apb_write(REG_SCL_HIGH, c.scl_high);
        apb_write(REG_DATA_SETUP, c.data_setup);
        apb_write(REG_DATA_HOLD, c.data_hold);
        apb_write(REG_START_HOLD, c.start_hold);
        apb_write(REG_STOP_SETUP, c.stop_setup);
        apb_write(REG_BUS_FREE, c.bus_free);
        apb_write(REG_ACK_TMO, c.ack_tmo);
        @(posedge clk);
    endtask

    // Issue one command from idle and tick it to completion; the slave answers
    // the ACK after ack_after high ticks, or never when ack_after is negative
    task automatic run_cmd(logic [2:0] f, logic [7:0] tx, logic sack, int ack_after);
        int         in_ack;
        logic       sda;
        logic [2:0] noise_f;
        in_ack = 0;
        if ($urandom_range(99) < 20)
        begin
            noise_f = ($urandom_range(1) == 0) ? FUNC_NONE : 3'($urandom_range(7, 5));
            drive_tick(noise_f, 8'($urandom), 1'($urandom), 1'($urandom));
        end
        drive_tick(f, tx, sack, 1'($urandom));
        while (sb.busy())
        begin
            sda = 1'($urandom);
            if (sb.waiting_ack())
            begin
                sda = (ack_after >= 0 && in_ack >= ack_after) ? 1'b0 : 1'b1;
                in_ack++;
            end
            noise_f = ($urandom_range(99) < 10) ? 3'($urandom_range(7)) : FUNC_NONE;
            drive_tick(noise_f, 8'($urandom), 1'($urandom), sda);
        end
    endtask

    function automatic int pick_ack();
        int cap;
        cap = (sb.cfg.ack_tmo > 8) ? 8 : int'(sb.cfg.ack_tmo);
        if ($urandom_range(99) < 25)
            return -1;
        return $urandom_range(cap);
    endfunction

    // Start, one to three bytes with an occasional repeated start, then usually stop
    task automatic run_transaction();
        int nbytes;
        run_cmd(FUNC_START, 8'($urandom), 1'($urandom), -1);
        nbytes = $urandom_range(3, 1);
        for (int b = 0; b < nbytes; b++)
        begin
            if (b > 0 && $urandom_range(5) == 0)
                run_cmd(FUNC_START, 8'($urandom), 1'($urandom), -1);
            if (b == 0 || $urandom_range(1) == 0)
                run_cmd(FUNC_WRITE, 8'($urandom), 1'($urandom), pick_ack());
            else
                run_cmd(FUNC_READ, 8'($urandom), 1'($urandom), -1);
        end
        if ($urandom_range(9) != 0)
            run_cmd(FUNC_STOP, 8'($urandom), 1'($urandom), -1);
    endtask

    task automatic random_traffic(int budget, int min_done);
        int t0;
        int d0;
        t0 = sb.ticks;
        d0 = sb.dones;
        while (sb.ticks - t0 < budget || sb.dones - d0 < min_done)
        begin
            if ($urandom_range(99) < 80)
                run_transaction();
            else
                run_cmd(3'($urandom_range(7)), 8'($urandom), 1'($urandom), pick_ack());
        end
    endtask

    function automatic int short_span(int lo);
        if ($urandom_range(9) == 0)
            return $urandom_range(12, lo);
        return $urandom_range(4, lo);
    endfunction

    initial
    begin
        int guard;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default timing straight after reset
        run_cmd(FUNC_START, 8'h00, 1'b0, -1);
        run_cmd(FUNC_STOP, 8'h00, 1'b0, -1);

        // Shortest times, zero durations and an ACK timeout of zero
        load_timing(make_timing(1, 1, 0, 0, 0, 0, 0, 0));
        run_cmd(FUNC_START, 8'h00, 1'b0, -1);
        run_cmd(FUNC_WRITE, 8'h00, 1'b1, -1);
        run_cmd(FUNC_START, 8'h00, 1'b0, -1);
        run_cmd(FUNC_WRITE, 8'hA5, 1'b0, 0);
        run_cmd(FUNC_READ, 8'hFF, 1'b0, -1);
        run_cmd(FUNC_READ, 8'h00, 1'b1, -1);
        run_cmd(FUNC_STOP, 8'h00, 1'b0, -1);
        run_cmd(FUNC_STOP, 8'hFF, 1'b1, -1);
        run_cmd(3'd7, 8'hFF, 1'b1, -1);
        run_cmd(FUNC_NONE, 8'h00, 1'b0, -1);

        // ACK on the last allowed tick, then a timeout of one tick
        load_timing(make_timing(1, 1, 0, 0, 0, 0, 0, 1));
        run_cmd(FUNC_START, 8'h00, 1'b0, -1);
        run_cmd(FUNC_WRITE, 8'h3C, 1'b0, 1);
        run_cmd(FUNC_WRITE, 8'hC3, 1'b0, -1);

        // Random traffic over several short timing sets
        for (int ph = 0; ph < 6; ph++)
        begin
            load_timing(make_timing(short_span(1), short_span(1), short_span(0),
                                    short_span(0), short_span(0), short_span(0),
                                    short_span(0), short_span(1)));
            if (ph == 1)
                quiet <= 1'b1;
            if (ph == 2)
                quiet <= 1'b0;
            if (ph == 4)
            begin
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end
            random_traffic(100, 2);
        end

        // Let the last results come back, then settle
        in_valid <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (sb.pending() != 0)
            $display("%0t: %0d expected result items never arrived", $time, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial
    begin
        #40000000;
        $display("FAIL");
        $finish;
    end

endmodule
